/* rtl/core/olt_pkg.sv */
// Shared constants and types for the ordered list table.
package olt_pkg;

  localparam int OP_W     = 2;
  localparam int POS_W    = 11;
  localparam int ITEM_W   = 32;
  localparam int STATUS_W = 3;
  localparam int RESULT_W = 32;
  localparam int FOUND_W  = 10;
  localparam int LENGTH_W = 11;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_LOCATE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic ins;
    logic del;
    logic scan;
    logic locate;
  } chain_ctrl_t;

  typedef struct packed {
    logic act;
    logic hit;
  } carry_t;

endpackage

/* rtl/core/ordered_list_table.sv */
// Top level of the ordered list table: request decode, list length and result register.
//
// Requests arrive on request_valid / request_stall with op, position and
// item_value; one result per request leaves on result_valid / result_stall
// with status, result_value, found_index and list_length.
// The list lives in a row of DEPTH cells. Insert shifts the cells as it
// is taken, so an insert, and any request rejected on its length or position,
// shows its result in the cycle after it is taken, and such requests can be
// taken back to back. Read, delete and locate send a scan carry down the
// row, one cell per cycle. When the carry leaves the last cell, the result
// is loaded in the finish state once the result register is free, and the
// next request is taken when the block is back in idle.
// One request is worked on at a time. A request is taken only while the
// result register is empty or being emptied in the same cycle, so a stalled
// receiver holds its result steady and stalls the request side in turn.
// Reset empties the list and the result register; entry values are not
// cleared, since positions beyond the length are never read.
module ordered_list_table #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              request_valid,
  output logic                              request_stall,
  input  logic [olt_pkg::OP_W-1:0]          op,
  input  logic [olt_pkg::POS_W-1:0]         position,
  input  logic [olt_pkg::ITEM_W-1:0]        item_value,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [olt_pkg::STATUS_W-1:0]      status,
  output logic [olt_pkg::RESULT_W-1:0]      result_value,
  output logic [olt_pkg::FOUND_W-1:0]       found_index,
  output logic [olt_pkg::LENGTH_W-1:0]      list_length
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int WIDE_W = CNT_W + 64;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [olt_pkg::OP_W-1:0] op_reg;
  logic [IDX_W-1:0]       pos_idx_reg;
  logic [VALUE_WIDTH-1:0] key_reg;
  logic                   hit_reg;
  logic [IDX_W-1:0]       idx_reg;
  logic [VALUE_WIDTH-1:0] val_reg;

  logic                   out_free;
  logic                   accept;
  logic [WIDE_W-1:0]      pos_wide;
  logic [WIDE_W-1:0]      cnt_wide;
  logic [WIDE_W-1:0]      pos_m1;
  logic [WIDE_W-1:0]      item_wide;
  logic [VALUE_WIDTH-1:0] key_in;
  logic                   full;
  logic                   ins_pos_ok;
  logic                   rd_pos_ok;
  logic                   imm_load;
  logic [olt_pkg::STATUS_W-1:0] imm_status;
  logic                   do_ins;
  logic                   do_scan;
  logic                   fin_load;
  logic [CNT_W-1:0]       count_inc;
  logic [CNT_W-1:0]       count_dec;
  logic [WIDE_W-1:0]      inc_wide;
  logic [WIDE_W-1:0]      dec_wide;
  logic [WIDE_W-1:0]      val_wide;
  logic [WIDE_W-1:0]      idx_wide;

  olt_pkg::chain_ctrl_t   ctrl;
  logic [IDX_W-1:0]       sel_pos_idx;
  logic [VALUE_WIDTH-1:0] sel_key;
  olt_pkg::carry_t        scan_out;
  logic [IDX_W-1:0]       scan_idx;
  logic [VALUE_WIDTH-1:0] scan_val;

  assign out_free      = !result_valid || !result_stall;
  assign request_stall = !((state == S_IDLE) && out_free);
  assign accept        = request_valid && !request_stall;

  assign pos_wide   = WIDE_W'(position);
  assign cnt_wide   = WIDE_W'(count);
  assign pos_m1     = pos_wide - WIDE_W'(1);
  assign item_wide  = WIDE_W'(item_value);
  assign key_in     = item_wide[VALUE_WIDTH-1:0];
  assign full       = (count == CNT_W'(DEPTH));
  assign ins_pos_ok = (pos_wide != '0) && (pos_wide <= cnt_wide + WIDE_W'(1));
  assign rd_pos_ok  = (pos_wide != '0) && (pos_wide <= cnt_wide);

  assign count_inc = count + CNT_W'(1);
  assign count_dec = count - CNT_W'(1);
  assign inc_wide  = WIDE_W'(count_inc);
  assign dec_wide  = WIDE_W'(count_dec);
  assign val_wide  = WIDE_W'(val_reg);
  assign idx_wide  = WIDE_W'(idx_reg);

  always_comb begin
    imm_load   = 1'b0;
    imm_status = olt_pkg::ST_OK;
    do_ins     = 1'b0;
    do_scan    = 1'b0;
    case (op)
      olt_pkg::OP_INSERT: begin
        imm_load = 1'b1;
        if (full) begin
          imm_status = olt_pkg::ST_FULL;
        end else if (!ins_pos_ok) begin
          imm_status = olt_pkg::ST_BAD_POS;
        end else begin
          do_ins = 1'b1;
        end
      end
      olt_pkg::OP_DELETE: begin
        if (count == '0) begin
          imm_load   = 1'b1;
          imm_status = olt_pkg::ST_EMPTY;
        end else if (!rd_pos_ok) begin
          imm_load   = 1'b1;
          imm_status = olt_pkg::ST_BAD_POS;
        end else begin
          do_scan = 1'b1;
        end
      end
      olt_pkg::OP_READ: begin
        if (!rd_pos_ok) begin
          imm_load   = 1'b1;
          imm_status = olt_pkg::ST_BAD_POS;
        end else begin
          do_scan = 1'b1;
        end
      end
      default: begin
        do_scan = 1'b1;
      end
    endcase
  end

  assign fin_load = (state == S_FIN) && out_free;

  always_comb begin
    if (state == S_IDLE) begin
      sel_pos_idx = pos_m1[IDX_W-1:0];
      sel_key     = key_in;
      ctrl.locate = (op == olt_pkg::OP_LOCATE);
    end else begin
      sel_pos_idx = pos_idx_reg;
      sel_key     = key_reg;
      ctrl.locate = (op_reg == olt_pkg::OP_LOCATE);
    end
    ctrl.ins  = accept && do_ins;
    ctrl.scan = accept && do_scan;
    ctrl.del  = fin_load && (op_reg == olt_pkg::OP_DELETE);
  end

  always_comb begin
    state_next = state;
    count_next = count;
    case (state)
      S_IDLE: begin
        if (accept && do_scan) begin
          state_next = S_SCAN;
        end
        if (ctrl.ins) begin
          count_next = count_inc;
        end
      end
      S_SCAN: begin
        if (scan_out.act) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
        if (ctrl.del) begin
          count_next = count_dec;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if ((accept && imm_load) || fin_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg      <= op;
      pos_idx_reg <= pos_m1[IDX_W-1:0];
      key_reg     <= key_in;
    end
    if ((state == S_SCAN) && scan_out.act) begin
      hit_reg <= scan_out.hit;
      idx_reg <= scan_idx;
      val_reg <= scan_val;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && imm_load) begin
      status       <= imm_status;
      result_value <= '0;
      found_index  <= '0;
      if (do_ins) begin
        list_length <= inc_wide[olt_pkg::LENGTH_W-1:0];
      end else begin
        list_length <= cnt_wide[olt_pkg::LENGTH_W-1:0];
      end
    end else if (fin_load) begin
      if (op_reg == olt_pkg::OP_LOCATE) begin
        result_value <= '0;
        if (hit_reg) begin
          status      <= olt_pkg::ST_OK;
          found_index <= idx_wide[olt_pkg::FOUND_W-1:0];
        end else begin
          status      <= olt_pkg::ST_NOT_FOUND;
          found_index <= '0;
        end
      end else begin
        status       <= olt_pkg::ST_OK;
        result_value <= val_wide[olt_pkg::RESULT_W-1:0];
        found_index  <= '0;
      end
      if (op_reg == olt_pkg::OP_DELETE) begin
        list_length <= dec_wide[olt_pkg::LENGTH_W-1:0];
      end else begin
        list_length <= cnt_wide[olt_pkg::LENGTH_W-1:0];
      end
    end
  end

  olt_chain #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .pos_idx (sel_pos_idx),
    .key     (sel_key),
    .count   (count),
    .scan_out(scan_out),
    .scan_idx(scan_idx),
    .scan_val(scan_val)
  );

endmodule

/* rtl/core/olt_cell.sv */
// One list entry with its shift muxes and one stage of the scan carry.
module olt_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter int IDX_W       = 10,
  parameter int CNT_W       = 11,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  olt_pkg::chain_ctrl_t   ctrl,
  input  logic [IDX_W-1:0]       pos_idx,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic [CNT_W-1:0]       count,
  input  logic [VALUE_WIDTH-1:0] left_value,
  input  logic [VALUE_WIDTH-1:0] right_value,
  output logic [VALUE_WIDTH-1:0] value,
  input  olt_pkg::carry_t        carry_in,
  input  logic [IDX_W-1:0]       carry_in_idx,
  input  logic [VALUE_WIDTH-1:0] carry_in_val,
  output olt_pkg::carry_t        carry_out,
  output logic [IDX_W-1:0]       carry_out_idx,
  output logic [VALUE_WIDTH-1:0] carry_out_val
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

  logic match;

  assign match = ctrl.locate ? ((MY_CNT < count) && (value == key)) : (MY_IDX == pos_idx);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (MY_IDX > pos_idx) begin
        value <= left_value;
      end else if (MY_IDX == pos_idx) begin
        value <= key;
      end
    end else if (ctrl.del) begin
      if (MY_IDX >= pos_idx) begin
        value <= right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out <= '0;
    end else begin
      carry_out.act <= carry_in.act;
      carry_out.hit <= carry_in.hit || match;
    end
  end

  always_ff @(posedge clk) begin
    if (carry_in.hit) begin
      carry_out_idx <= carry_in_idx;
      carry_out_val <= carry_in_val;
    end else begin
      carry_out_idx <= MY_IDX;
      carry_out_val <= value;
    end
  end

endmodule

/* rtl/core/olt_chain.sv */
// Row of list cells with neighbor shifting and the rippling scan carry.
module olt_chain #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32,
  parameter int IDX_W       = 10,
  parameter int CNT_W       = 11
) (
  input  logic                   clk,
  input  logic                   rst,
  input  olt_pkg::chain_ctrl_t   ctrl,
  input  logic [IDX_W-1:0]       pos_idx,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic [CNT_W-1:0]       count,
  output olt_pkg::carry_t        scan_out,
  output logic [IDX_W-1:0]       scan_idx,
  output logic [VALUE_WIDTH-1:0] scan_val
);

  logic [VALUE_WIDTH-1:0] values [DEPTH];
  olt_pkg::carry_t        carry  [DEPTH+1];
  logic [IDX_W-1:0]       c_idx  [DEPTH+1];
  logic [VALUE_WIDTH-1:0] c_val  [DEPTH+1];

  assign carry[0].act = ctrl.scan;
  assign carry[0].hit = 1'b0;
  assign c_idx[0]     = '0;
  assign c_val[0]     = '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_v;
    logic [VALUE_WIDTH-1:0] right_v;

    if (k == 0) begin : g_first
      assign left_v = key;
    end else begin : g_mid
      assign left_v = values[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_v = values[k];
    end else begin : g_inner
      assign right_v = values[k+1];
    end

    olt_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .INDEX      (k)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .pos_idx      (pos_idx),
      .key          (key),
      .count        (count),
      .left_value   (left_v),
      .right_value  (right_v),
      .value        (values[k]),
      .carry_in     (carry[k]),
      .carry_in_idx (c_idx[k]),
      .carry_in_val (c_val[k]),
      .carry_out    (carry[k+1]),
      .carry_out_idx(c_idx[k+1]),
      .carry_out_val(c_val[k+1])
    );
  end

  assign scan_out = carry[DEPTH];
  assign scan_idx = c_idx[DEPTH];
  assign scan_val = c_val[DEPTH];

endmodule

/* rtl/core/olt_checker.sv */
// Port-level checks for the ordered list table and the bind that attaches them.
module olt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         request_valid,
  input logic                         request_stall,
  input logic [olt_pkg::OP_W-1:0]     op,
  input logic                         result_valid,
  input logic                         result_stall,
  input logic [olt_pkg::STATUS_W-1:0] status,
  input logic [olt_pkg::LENGTH_W-1:0] list_length
);

  // Reset leaves an empty result register and a block ready for requests.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!result_valid && !request_stall))
    else $error("result or stall active after reset");

  // An insert result is loaded into the result register as the insert is taken.
  a_insert_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (request_valid && !request_stall && (op == olt_pkg::OP_INSERT)) |=> result_valid)
    else $error("insert result not presented one cycle after request");

  // A new request is never taken while a stalled result is still held.
  a_no_take_on_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> request_stall)
    else $error("request taken while result is held");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(status) && $stable(list_length)))
    else $error("stalled result changed");

endmodule

bind ordered_list_table olt_checker u_olt_checker (
  .clk          (clk),
  .rst          (rst),
  .request_valid(request_valid),
  .request_stall(request_stall),
  .op           (op),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .status       (status),
  .list_length  (list_length)
);

/* test/tb_ordered_list_table.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the ordered list table against a positional list model.

module tb_ordered_list_table;
  import olt_pkg::*;

  localparam int LIST_DEPTH      = 1024;
  localparam int VALUE_W         = 32;
  localparam int RANDOM_REQUESTS = 1250;
  localparam int IDLE_LIMIT      = 40000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RESULT_W-1:0] value;
    logic [FOUND_W-1:0]  index;
    logic [LENGTH_W-1:0] length;
  } list_result_t;

  class ordered_list_checker;
    logic [ITEM_W-1:0] list_entries[$];
    list_result_t      pending_results[$];
    int                errors;

    function int entry_count();
      return list_entries.size();
    endfunction

    function logic [ITEM_W-1:0] entry_at(int idx);
      return list_entries[idx];
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void note_request(logic [OP_W-1:0] req_op, logic [POS_W-1:0] pos,
                               logic [ITEM_W-1:0] val);
      list_result_t res;
      int n;
      res = '0;
      n = list_entries.size();
      case (req_op)
        OP_INSERT: begin
          if (n >= LIST_DEPTH) begin
            res.status = ST_FULL;
          end else if (pos < 1 || pos > n + 1) begin
            res.status = ST_BAD_POS;
          end else begin
            list_entries.insert(pos - 1, val);
          end
        end
        OP_DELETE: begin
          if (n == 0) begin
            res.status = ST_EMPTY;
          end else if (pos < 1 || pos > n) begin
            res.status = ST_BAD_POS;
          end else begin
            res.value = list_entries[pos - 1];
            list_entries.delete(pos - 1);
          end
        end
        OP_READ: begin
          if (pos < 1 || pos > n) begin
            res.status = ST_BAD_POS;
          end else begin
            res.value = list_entries[pos - 1];
          end
        end
        default: begin
          res.status = ST_NOT_FOUND;
          for (int k = 0; k < n; k++) begin
            if (list_entries[k] == val) begin
              res.status = ST_OK;
              res.index  = FOUND_W'(k);
              break;
            end
          end
        end
      endcase
      res.length = LENGTH_W'(list_entries.size());
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [RESULT_W-1:0] rv,
                               logic [FOUND_W-1:0] fi, logic [LENGTH_W-1:0] len);
      list_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0d value %h index %0d length %0d",
                 $time, st, rv, fi, len);
        return;
      end
      want = pending_results.pop_front();
      if (st !== want.status) begin
        errors++;
        $display("%0t: status expected %0d, got %0d", $time, want.status, st);
      end
      if (rv !== want.value) begin
        errors++;
        $display("%0t: result_value expected %h, got %h", $time, want.value, rv);
      end
      if (fi !== want.index) begin
        errors++;
        $display("%0t: found_index expected %0d, got %0d", $time, want.index, fi);
      end
      if (len !== want.length) begin
        errors++;
        $display("%0t: list_length expected %0d, got %0d", $time, want.length, len);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                request_valid;
  logic                request_stall;
  logic [OP_W-1:0]     op;
  logic [POS_W-1:0]    position;
  logic [ITEM_W-1:0]   item_value;
  logic                result_valid;
  logic                result_stall;
  logic [STATUS_W-1:0] status;
  logic [RESULT_W-1:0] result_value;
  logic [FOUND_W-1:0]  found_index;
  logic [LENGTH_W-1:0] list_length;

  ordered_list_checker board;
  bit                  steady;
  int                  idle_count;

  ordered_list_table #(
    .DEPTH(LIST_DEPTH),
    .VALUE_WIDTH(VALUE_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .op(op),
    .position(position),
    .item_value(item_value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .status(status),
    .result_value(result_value),
    .found_index(found_index),
    .list_length(list_length)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [ITEM_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 45) return ITEM_W'($urandom_range(0, 15));
    return $urandom;
  endfunction

  // Called and returning at a falling edge; holds the request until it is taken.
  task automatic send_request(input logic [OP_W-1:0] req_op, input logic [POS_W-1:0] pos,
                              input logic [ITEM_W-1:0] val);
    int gap;
    gap = steady ? 0 : idle_cycles();
    if (gap > 0) begin
      request_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    request_valid = 1'b1;
    op            = req_op;
    position      = pos;
    item_value    = val;
    do @(posedge clk); while (request_stall);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        board.check_result(status, result_value, found_index, list_length);
      end
      if (request_valid && !request_stall) begin
        board.note_request(op, position, item_value);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (request_valid && !request_stall) || (result_valid && !result_stall)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int stall_len;
    result_stall = 1'b0;
    forever begin
      repeat ($urandom_range(1, 8)) @(negedge clk);
      stall_len = steady ? 0 : idle_cycles();
      if (stall_len > 0) begin
        result_stall = 1'b1;
        repeat (stall_len) @(negedge clk);
        result_stall = 1'b0;
      end
    end
  end

  initial begin
    int                sent;
    int                after_full;
    int                c;
    int                r;
    bit                growing;
    bit                full_seen;
    logic [OP_W-1:0]   o;
    logic [POS_W-1:0]  p;
    logic [ITEM_W-1:0] v;

    board         = new();
    steady        = 1'b0;
    rst           = 1'b1;
    request_valid = 1'b0;
    op            = OP_INSERT;
    position      = '0;
    item_value    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_request(OP_DELETE, 11'd1, 32'h0);
    send_request(OP_READ, 11'd1, 32'h0);
    send_request(OP_LOCATE, 11'd0, 32'h0);
    send_request(OP_INSERT, 11'd0, 32'h1);
    send_request(OP_INSERT, 11'd2, 32'h1);
    send_request(OP_INSERT, 11'd1, 32'h0);
    send_request(OP_INSERT, 11'd2, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 11'd1, 32'h5555_AAAA);
    send_request(OP_INSERT, 11'd3, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 11'd2047, 32'h1);
    send_request(OP_READ, 11'd1, 32'h0);
    send_request(OP_READ, 11'd4, 32'h0);
    send_request(OP_READ, 11'd5, 32'h0);
    send_request(OP_READ, 11'd0, 32'h0);
    send_request(OP_READ, 11'd2047, 32'h0);
    send_request(OP_LOCATE, 11'd0, 32'hFFFF_FFFF);
    send_request(OP_LOCATE, 11'd2047, 32'h0);
    send_request(OP_LOCATE, 11'd1, 32'hAAAA_5555);
    send_request(OP_DELETE, 11'd0, 32'h0);
    send_request(OP_DELETE, 11'd5, 32'h0);
    send_request(OP_DELETE, 11'd2, 32'h0);
    send_request(OP_DELETE, 11'd3, 32'h0);
    send_request(OP_DELETE, 11'd1, 32'h0);
    send_request(OP_DELETE, 11'd1, 32'h0);

    // The list grows until it is full, then mostly drains for a while.
    sent       = 0;
    after_full = 0;
    growing    = 1'b1;
    full_seen  = 1'b0;
    while (sent < RANDOM_REQUESTS || !full_seen || after_full < 80) begin
      steady = ((sent / 150) % 4) == 3;
      c = board.entry_count();
      if (c >= LIST_DEPTH) begin
        full_seen = 1'b1;
        if ($urandom_range(0, 3) == 0) growing = 1'b0;
      end else if (c < 8 && !growing) begin
        growing = 1'b1;
      end
      if (full_seen) after_full++;

      r = $urandom_range(0, 99);
      if (growing) begin
        o = (r < 95) ? OP_INSERT : (r < 97) ? OP_DELETE : (r < 98) ? OP_READ : OP_LOCATE;
      end else begin
        o = (r < 15) ? OP_INSERT : (r < 75) ? OP_DELETE : (r < 88) ? OP_READ : OP_LOCATE;
      end

      r = $urandom_range(0, 99);
      if (o == OP_INSERT) begin
        if (r < 94) p = POS_W'($urandom_range(1, c + 1));
        else if (r < 96) p = '0;
        else if (r < 98) p = POS_W'(c + 2);
        else p = POS_W'($urandom_range(0, 2047));
      end else begin
        if (c > 0 && r < 88) p = POS_W'($urandom_range(1, c));
        else if (r < 92) p = '0;
        else if (r < 96) p = POS_W'(c + 1);
        else p = POS_W'($urandom_range(0, 2047));
      end

      v = pick_value();
      if (o == OP_LOCATE && c > 0 && $urandom_range(0, 9) < 6) begin
        v = board.entry_at($urandom_range(0, c - 1));
      end
      send_request(o, p, v);
      sent++;
    end

    steady        = 1'b0;
    request_valid = 1'b0;
    while (board.outstanding() > 0) @(posedge clk);
    repeat (LIST_DEPTH + 4) @(posedge clk);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
